>>> rtl/core/s2e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2e_pkg
// Shared defaults for the symmetric 2x2 eigen decomposition core.
// ----------------------------------------------------------------------------
package s2e_pkg;

  // Default width of one tensor element and of one eigenvalue.
  localparam int S2E_DATA_WIDTH = 32;
  // Default number of fraction bits in the fixed-point formats.
  localparam int S2E_FRAC_BITS  = 16;

endpackage

>>> rtl/core/sym2x2_eigen_decompose_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sym2x2_eigen_decompose_core
// Pipelined eigenvalues and unit eigenvectors of a symmetric 2x2 tensor.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the slave stream carries one tensor (s_xx, s_xy, s_yy) in
//   signed fixed point. The master stream returns one result per request, in
//   order: the larger and smaller eigenvalue (saturated) and the unit
//   eigenvectors of both, each component in Q1.FRAC_BITS, rounded to nearest.
//   The depth is set by the digit-by-digit square roots, one root bit per
//   stage for the eigenvalue spread and for the vector norms, and by the
//   restoring dividers, one quotient bit per stage.
//   Throughput is one request per cycle unless the output stalls; a new
//   request enters while older ones are still in flight.
//   When the receiver holds m_tready low with a result waiting, the whole
//   pipeline freezes and s_tready falls, so nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty afterwards and
//   s_tready is high.
// ----------------------------------------------------------------------------
module sym2x2_eigen_decompose_core #(
  parameter int DATA_WIDTH = s2e_pkg::S2E_DATA_WIDTH,
  parameter int FRAC_BITS  = s2e_pkg::S2E_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata fields from bit 0: s_xx, s_xy, s_yy, zero padding
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata fields from bit 0: eig_large, eig_small, vec_major_x,
  // vec_major_y, vec_minor_x, vec_minor_y, zero padding
  output logic [((2*DATA_WIDTH+4*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);

  localparam int DW    = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int VW    = FB + 2;
  localparam int OUT_W = ((2*DW + 4*VW + 7)/8)*8;
  localparam int K1    = DW + 1;
  localparam int N1W   = 2*K1;
  localparam int MW    = DW + 2;
  localparam int K2    = MW;
  localparam int N2W   = 2*K2;
  localparam int Q     = FB + 2;
  localparam int NUMW  = MW + FB + 2;
  localparam int DENW  = MW + 1;
  localparam int SB1W  = 3*(DW+1) + 2;
  localparam int SB2W  = 2*DW + 3*MW + 5;
  localparam int SB3W  = 2*DW + 5;
  localparam int LAT   = 10 + K1 + K2 + Q;

  logic           adv;
  logic [LAT-1:0] vld;

  // The pipeline advances as one unit whenever the output slot can move.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[LAT-1];

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Stage A: difference, trace and doubled off-diagonal.
  logic [DW-1:0]        in_xx, in_xy, in_yy;
  logic signed [DW:0]   a_d, a_t, a_y2;
  logic                 a_nz, a_ge;

  assign in_xx = s_tdata[DW-1:0];
  assign in_xy = s_tdata[2*DW-1:DW];
  assign in_yy = s_tdata[3*DW-1:2*DW];

  always_ff @(posedge clk) begin
    if (adv) begin
      a_d  <= $signed({in_xx[DW-1], in_xx}) - $signed({in_yy[DW-1], in_yy});
      a_t  <= $signed({in_xx[DW-1], in_xx}) + $signed({in_yy[DW-1], in_yy});
      a_y2 <= $signed({in_xy, 1'b0});
      a_nz <= |in_xy;
      a_ge <= $signed(in_xx) >= $signed(in_yy);
    end
  end

  // Stage B: squares of the magnitudes.
  logic [DW:0]      a_ad, a_ay;
  logic [N1W-1:0]   b_sqd, b_sqy;
  logic [SB1W-1:0]  b_sb;

  assign a_ad = a_d[DW]  ? (DW+1)'(-a_d)  : a_d;
  assign a_ay = a_y2[DW] ? (DW+1)'(-a_y2) : a_y2;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sqd <= a_ad * a_ad;
      b_sqy <= a_ay * a_ay;
      b_sb  <= {a_t, a_d, a_y2, a_nz, a_ge};
    end
  end

  // Stage C: radicand of the eigenvalue spread.
  logic [N1W-1:0]  c_n;
  logic [SB1W-1:0] c_sb;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_n  <= b_sqd + b_sqy;
      c_sb <= b_sb;
    end
  end

  // First square root: one root bit per stage, two radicand bits consumed.
  logic [K1-1:0]   sq1_root [0:K1-1];
  logic [K1+1:0]   sq1_rem  [0:K1-1];
  logic [N1W-1:0]  sq1_n    [0:K1-1];
  logic [SB1W-1:0] sq1_sb   [0:K1-1];

  for (genvar g = 0; g < K1; g++) begin : g_sq1
    logic [K1-1:0]   root_in;
    logic [K1+1:0]   rem_in;
    logic [N1W-1:0]  n_in;
    logic [SB1W-1:0] sb_in;
    logic [K1+3:0]   rem_sh, trial;

    if (g == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign n_in    = c_n;
      assign sb_in   = c_sb;
    end else begin : g_next
      assign root_in = sq1_root[g-1];
      assign rem_in  = sq1_rem[g-1];
      assign n_in    = sq1_n[g-1];
      assign sb_in   = sq1_sb[g-1];
    end

    assign rem_sh = {rem_in, n_in[N1W-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          sq1_rem[g]  <= (K1+2)'(rem_sh - trial);
          sq1_root[g] <= {root_in[K1-2:0], 1'b1};
        end else begin
          sq1_rem[g]  <= (K1+2)'(rem_sh);
          sq1_root[g] <= {root_in[K1-2:0], 1'b0};
        end
        sq1_n[g]  <= {n_in[N1W-3:0], 2'b00};
        sq1_sb[g] <= sb_in;
      end
    end
  end

  // Stage D: round the spread to nearest.
  logic [K1-1:0]   d_delta;
  logic [SB1W-1:0] d_sb;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_delta <= sq1_root[K1-1] +
                 K1'(sq1_rem[K1-1] > {2'b00, sq1_root[K1-1]});
      d_sb    <= sq1_sb[K1-1];
    end
  end

  // Stage E: eigenvalues with floor halving and saturation, vector x terms.
  logic signed [DW:0]   d_t, d_d, d_y2;
  logic                 d_nz, d_ge;
  logic signed [DW+2:0] d_tx, d_dx, d_dl, d_sl, d_ss, d_hl, d_hs;
  logic [DW-1:0]        d_el, d_es;
  logic [DW-1:0]        sat_max, sat_min;

  assign d_t  = d_sb[SB1W-1 -: DW+1];
  assign d_d  = d_sb[SB1W-DW-2 -: DW+1];
  assign d_y2 = d_sb[SB1W-2*DW-3 -: DW+1];
  assign d_nz = d_sb[1];
  assign d_ge = d_sb[0];

  assign d_tx = {{2{d_t[DW]}}, d_t};
  assign d_dx = {{2{d_d[DW]}}, d_d};
  assign d_dl = {2'b00, d_delta};
  assign d_sl = d_tx + d_dl;
  assign d_ss = d_tx - d_dl;
  assign d_hl = d_sl >>> 1;
  assign d_hs = d_ss >>> 1;
  assign sat_max = {1'b0, {(DW-1){1'b1}}};
  assign sat_min = {1'b1, {(DW-1){1'b0}}};

  // A halved sum fits when its top bits are all copies of the sign.
  always_comb begin
    if (d_hl[DW+2:DW-1] == '0 || d_hl[DW+2:DW-1] == '1) begin
      d_el = d_hl[DW-1:0];
    end else begin
      d_el = d_hl[DW+2] ? sat_min : sat_max;
    end
    if (d_hs[DW+2:DW-1] == '0 || d_hs[DW+2:DW-1] == '1) begin
      d_es = d_hs[DW-1:0];
    end else begin
      d_es = d_hs[DW+2] ? sat_min : sat_max;
    end
  end

  logic [DW-1:0]        e_el, e_es;
  logic signed [DW+2:0] e_mx, e_nx;
  logic signed [DW:0]   e_y2;
  logic                 e_nz, e_ge;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_el <= d_el;
      e_es <= d_es;
      e_mx <= d_dx + d_dl;
      e_nx <= d_dx - d_dl;
      e_y2 <= d_y2;
      e_nz <= d_nz;
      e_ge <= d_ge;
    end
  end

  // Stage F: component magnitudes and their squares.
  logic [MW-1:0]   e_amx, e_anx, e_ay;
  logic [N2W-1:0]  f_sqm, f_sqn, f_sqy;
  logic [SB2W-1:0] f_sb;

  assign e_amx = e_mx[DW+2] ? MW'(-e_mx) : MW'(e_mx);
  assign e_anx = e_nx[DW+2] ? MW'(-e_nx) : MW'(e_nx);
  assign e_ay  = e_y2[DW]   ? MW'(-e_y2) : MW'(e_y2);

  always_ff @(posedge clk) begin
    if (adv) begin
      f_sqm <= e_amx * e_amx;
      f_sqn <= e_anx * e_anx;
      f_sqy <= e_ay * e_ay;
      f_sb  <= {e_el, e_es, e_amx, e_anx, e_ay,
                e_mx[DW+2], e_nx[DW+2], e_y2[DW], e_nz, e_ge};
    end
  end

  // Stage G: squared norms of the major and minor vectors.
  logic [N2W-1:0]  g_n [0:1];
  logic [SB2W-1:0] g_sb;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_n[0] <= f_sqm + f_sqy;
      g_n[1] <= f_sqn + f_sqy;
      g_sb   <= f_sb;
    end
  end

  // Second square root, two lanes for the two vector norms.
  logic [K2-1:0]   sq2_root [0:1][0:K2-1];
  logic [K2+1:0]   sq2_rem  [0:1][0:K2-1];
  logic [N2W-1:0]  sq2_n    [0:1][0:K2-1];
  logic [SB2W-1:0] sq2_sb   [0:K2-1];

  for (genvar l = 0; l < 2; l++) begin : g_sq2_lane
    for (genvar g = 0; g < K2; g++) begin : g_sq2
      logic [K2-1:0]  root_in;
      logic [K2+1:0]  rem_in;
      logic [N2W-1:0] n_in;
      logic [K2+3:0]  rem_sh, trial;

      if (g == 0) begin : g_first
        assign root_in = '0;
        assign rem_in  = '0;
        assign n_in    = g_n[l];
      end else begin : g_next
        assign root_in = sq2_root[l][g-1];
        assign rem_in  = sq2_rem[l][g-1];
        assign n_in    = sq2_n[l][g-1];
      end

      assign rem_sh = {rem_in, n_in[N2W-1 -: 2]};
      assign trial  = {2'b00, root_in, 2'b01};

      always_ff @(posedge clk) begin
        if (adv) begin
          if (rem_sh >= trial) begin
            sq2_rem[l][g]  <= (K2+2)'(rem_sh - trial);
            sq2_root[l][g] <= {root_in[K2-2:0], 1'b1};
          end else begin
            sq2_rem[l][g]  <= (K2+2)'(rem_sh);
            sq2_root[l][g] <= {root_in[K2-2:0], 1'b0};
          end
          sq2_n[l][g] <= {n_in[N2W-3:0], 2'b00};
        end
      end
    end
  end

  // Side data follows the norm lanes.
  for (genvar g = 0; g < K2; g++) begin : g_sq2_sb
    always_ff @(posedge clk) begin
      if (adv) begin
        sq2_sb[g] <= (g == 0) ? g_sb : sq2_sb[(g == 0) ? 0 : g-1];
      end
    end
  end

  // Stage H: round the norms, never below one.
  logic [K2-1:0]   h_rnd  [0:1];
  logic [K2-1:0]   h_norm [0:1];
  logic [SB2W-1:0] h_sb;

  for (genvar l = 0; l < 2; l++) begin : g_round2
    assign h_rnd[l] = sq2_root[l][K2-1] +
                      K2'(sq2_rem[l][K2-1] > {2'b00, sq2_root[l][K2-1]});
    always_ff @(posedge clk) begin
      if (adv) begin
        h_norm[l] <= (h_rnd[l] == '0) ? K2'(1) : h_rnd[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_sb <= sq2_sb[K2-1];
    end
  end

  // Stage I: rounding numerators 2|c|*2^FB + n and denominators 2n.
  // Lanes: major x, major y, minor x, minor y.
  logic [MW-1:0]   h_amx, h_anx, h_ay;
  logic [MW-1:0]   h_c    [0:3];
  logic [K2-1:0]   h_nsel [0:3];
  logic [NUMW-1:0] i_num  [0:3];
  logic [DENW-1:0] i_den  [0:3];
  logic [SB3W-1:0] i_sb;

  assign h_amx = h_sb[SB2W-2*DW-1 -: MW];
  assign h_anx = h_sb[SB2W-2*DW-MW-1 -: MW];
  assign h_ay  = h_sb[SB2W-2*DW-2*MW-1 -: MW];
  assign h_c[0] = h_amx;
  assign h_c[1] = h_ay;
  assign h_c[2] = h_anx;
  assign h_c[3] = h_ay;
  assign h_nsel[0] = h_norm[0];
  assign h_nsel[1] = h_norm[0];
  assign h_nsel[2] = h_norm[1];
  assign h_nsel[3] = h_norm[1];

  for (genvar l = 0; l < 4; l++) begin : g_numer
    always_ff @(posedge clk) begin
      if (adv) begin
        i_num[l] <= NUMW'({h_c[l], {(FB+1){1'b0}}}) + NUMW'(h_nsel[l]);
        i_den[l] <= {h_nsel[l], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_sb <= {h_sb[SB2W-1 -: 2*DW], h_sb[4:0]};
    end
  end

  // Restoring dividers, one quotient bit per stage, four lanes.
  logic [DENW-1:0] dv_rem [0:3][0:Q-1];
  logic [Q-1:0]    dv_num [0:3][0:Q-1];
  logic [Q-1:0]    dv_q   [0:3][0:Q-1];
  logic [DENW-1:0] dv_den [0:3][0:Q-1];
  logic [SB3W-1:0] dv_sb  [0:Q-1];

  for (genvar l = 0; l < 4; l++) begin : g_div_lane
    for (genvar g = 0; g < Q; g++) begin : g_div
      logic [DENW-1:0] rem_in, den_in;
      logic [Q-1:0]    num_in, q_in;
      logic [DENW:0]   r;

      if (g == 0) begin : g_first
        assign rem_in = DENW'(i_num[l][NUMW-1:Q]);
        assign num_in = i_num[l][Q-1:0];
        assign q_in   = '0;
        assign den_in = i_den[l];
      end else begin : g_next
        assign rem_in = dv_rem[l][g-1];
        assign num_in = dv_num[l][g-1];
        assign q_in   = dv_q[l][g-1];
        assign den_in = dv_den[l][g-1];
      end

      assign r = {rem_in, num_in[Q-1]};

      always_ff @(posedge clk) begin
        if (adv) begin
          if (r >= {1'b0, den_in}) begin
            dv_rem[l][g] <= DENW'(r - {1'b0, den_in});
            dv_q[l][g]   <= {q_in[Q-2:0], 1'b1};
          end else begin
            dv_rem[l][g] <= DENW'(r);
            dv_q[l][g]   <= {q_in[Q-2:0], 1'b0};
          end
          dv_num[l][g] <= {num_in[Q-2:0], 1'b0};
          dv_den[l][g] <= den_in;
        end
      end
    end
  end

  for (genvar g = 0; g < Q; g++) begin : g_div_sb
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_sb[g] <= (g == 0) ? i_sb : dv_sb[(g == 0) ? 0 : g-1];
      end
    end
  end

  // Output stage: clamp to one, restore signs, or pick the axes.
  logic [SB3W-1:0]      z_sb;
  logic                 z_sm, z_sn, z_sy, z_nz, z_ge;
  logic [VW-1:0]        one_q;
  logic [VW-1:0]        z_mag [0:3];
  logic [VW-1:0]        z_sgn [0:3];
  logic                 z_neg [0:3];
  logic [DW-1:0]        o_el, o_es;
  logic signed [VW-1:0] o_mx, o_my, o_nx, o_ny;

  assign z_sb  = dv_sb[Q-1];
  assign z_sm  = z_sb[4];
  assign z_sn  = z_sb[3];
  assign z_sy  = z_sb[2];
  assign z_nz  = z_sb[1];
  assign z_ge  = z_sb[0];
  assign one_q = VW'(1) << FB;
  assign z_neg[0] = z_sm;
  assign z_neg[1] = z_sy;
  assign z_neg[2] = z_sn;
  assign z_neg[3] = z_sy;

  for (genvar l = 0; l < 4; l++) begin : g_fix
    assign z_mag[l] = (dv_q[l][Q-1] > one_q) ? one_q : dv_q[l][Q-1];
    assign z_sgn[l] = z_neg[l] ? VW'(-z_mag[l]) : z_mag[l];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_el <= z_sb[SB3W-1 -: DW];
      o_es <= z_sb[SB3W-DW-1 -: DW];
      if (z_nz) begin
        o_mx <= z_sgn[0];
        o_my <= z_sgn[1];
        o_nx <= z_sgn[2];
        o_ny <= z_sgn[3];
      end else if (z_ge) begin
        o_mx <= one_q;
        o_my <= '0;
        o_nx <= '0;
        o_ny <= one_q;
      end else begin
        o_mx <= '0;
        o_my <= one_q;
        o_nx <= one_q;
        o_ny <= '0;
      end
    end
  end

  assign m_tdata = OUT_W'({o_ny, o_nx, o_my, o_mx, o_es, o_el});

  // Checks on the datapath and the stall logic.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(o_el) >= $signed(o_es))
    else $error("larger eigenvalue below smaller one");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_mx <= $signed(one_q) && o_mx >= -$signed(one_q) &&
                  o_ny <= $signed(one_q) && o_ny >= -$signed(one_q)))
    else $error("vector component beyond unit range");

  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without an output stall");

endmodule
